@@ rtl/core/bau_pkg.sv @@
// ----------------------------------------------------------------------------
// bau_pkg: shared types and constants for the buddy allocator unit
// Request and result codes, controller ops and the ctrl/datapath link structs.
// ----------------------------------------------------------------------------
package bau_pkg;

  localparam int ORDER_MAX_DEF = 10;   // default log2 of the largest pool
  localparam int ORD_W         = 5;    // internal order width (holds up to 31)

  localparam logic [3:0] POOL_ORDER_RST = 4'd10;

  localparam logic       REQ_ALLOC = 1'b0;
  localparam logic       REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OOM    = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SRD, S_SCHK, S_TAKE, S_SPLIT,
    S_FRD, S_FCHK, S_MRD, S_MCHK, S_PUT, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CFG, OP_CLR, OP_LOAD, OP_SRD, OP_SCHK, OP_TAKE, OP_SPLIT,
    OP_OOM, OP_FRD, OP_FCHK, OP_MRD, OP_MCHK, OP_PUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic busy;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_free_req;
    logic lvl_over;
    logic node_free;
    logic split_more;
    logic alloc_hit;
    logic merge_more;
  } stat_t;

endpackage

@@ rtl/core/bau_ctrl.sv @@
// ----------------------------------------------------------------------------
// bau_ctrl: sequencer for the buddy allocator
// Walks clear, search/split and lookup/merge; at most one datapath op a cycle.
// ----------------------------------------------------------------------------
module bau_ctrl import bau_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  logic  cfg_valid,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.busy   = (state != S_IDLE);
    cmd.done   = 1'b0;
    case (state)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = S_SRD;
        end else if (cfg_valid) begin
          cmd.op     = OP_CFG;
          state_next = S_CLR;
        end
      end
      S_SRD: begin
        // free requests branch off here; the load already captured the type
        if (stat.is_free_req) begin
          cmd.op     = OP_FRD;
          state_next = S_FCHK;
        end else if (stat.lvl_over) begin
          cmd.op     = OP_OOM;
          state_next = S_DONE;
        end else begin
          cmd.op     = OP_SRD;
          state_next = S_SCHK;
        end
      end
      S_SCHK: begin
        cmd.op     = OP_SCHK;
        state_next = stat.node_free ? S_TAKE : S_SRD;
      end
      S_TAKE: begin
        cmd.op     = OP_TAKE;
        state_next = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.op = OP_SPLIT;
        if (!stat.split_more) state_next = S_DONE;
      end
      S_FRD: begin
        state_next = S_FCHK;
      end
      S_FCHK: begin
        cmd.op     = OP_FCHK;
        state_next = stat.alloc_hit ? S_MRD : S_DONE;
      end
      S_MRD: begin
        if (stat.merge_more) begin
          cmd.op     = OP_MRD;
          state_next = S_MCHK;
        end else begin
          state_next = S_PUT;
        end
      end
      S_MCHK: begin
        cmd.op     = OP_MCHK;
        state_next = stat.node_free ? S_MRD : S_PUT;
      end
      S_PUT: begin
        cmd.op     = OP_PUT;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.done   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

endmodule

@@ rtl/core/bau_dp.sv @@
// ----------------------------------------------------------------------------
// bau_dp: datapath of the buddy allocator
// Free-node tree map, allocation table, walk registers and result registers.
// ----------------------------------------------------------------------------
module bau_dp import bau_pkg::*; #(
  parameter int ORDER_MAX = ORDER_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic [3:0]  pool_order,
  input  logic        req_type,
  input  logic [10:0] size,
  input  logic [9:0]  address,
  output stat_t       stat,
  output logic [1:0]  status,
  output logic [9:0]  address_res,
  output logic [3:0]  order
);

  localparam int AW = ORDER_MAX;
  localparam int NW = ORDER_MAX + 1;

  // tree map, node 1 spans 2^ORDER_MAX units; alloc table holds {valid, order}
  logic             fm [2**NW];
  logic [ORD_W:0]   am [2**AW];

  logic [3:0]       po_reg;
  logic [ORD_W-1:0] po;
  logic [NW-1:0]    clr;
  logic             req;
  logic [ORD_W-1:0] need;
  logic [ORD_W-1:0] lvl;
  logic [AW-1:0]    j;
  logic [AW-1:0]    a;
  logic             fm_rd;
  logic [ORD_W:0]   am_rd;

  logic             fm_we, fm_wd, am_we, fm_re, am_re;
  logic [NW-1:0]    fm_wa, fm_ra;
  logic [AW-1:0]    am_wa;
  logic [ORD_W:0]   am_wd;
  logic [ORD_W-1:0] need_in;
  logic [AW-1:0]    lim_m1;
  logic [AW-1:0]    bit_l;
  logic [AW-1:0]    bit_lm1;

  function automatic logic [NW-1:0] node_of(input logic [ORD_W-1:0] o,
                                            input logic [AW-1:0] ad);
    logic [NW-1:0] base;
    logic [NW-1:0] off;
    base = NW'(1) << (ORD_W'(ORDER_MAX) - o);
    off  = NW'(ad >> o);
    return base + off;
  endfunction

  assign po = (ORD_W'(po_reg) > ORD_W'(ORDER_MAX)) ? ORD_W'(ORDER_MAX) : ORD_W'(po_reg);

  // order needed: count of powers of two below the size (size 0 acts as 1)
  always_comb begin
    need_in = '0;
    for (int n = 0; n < 12; n++) begin
      if ((12'd1 << n) < {1'b0, size}) need_in = need_in + ORD_W'(1);
    end
  end

  assign lim_m1  = ~(~AW'(0) << (po - lvl));
  assign bit_l   = AW'(1) << lvl;
  assign bit_lm1 = AW'(1) << (lvl - ORD_W'(1));

  assign stat.clr_last    = &clr;
  assign stat.is_free_req = req;
  assign stat.lvl_over    = (lvl > po);
  assign stat.node_free   = fm_rd;
  assign stat.split_more  = (lvl > need);
  assign stat.alloc_hit   = am_rd[ORD_W];
  assign stat.merge_more  = (lvl < po);

  // memory port muxing
  always_comb begin
    fm_we = 1'b0; fm_wa = '0; fm_wd = 1'b0;
    fm_re = 1'b0; fm_ra = '0;
    am_we = 1'b0; am_wa = '0; am_wd = '0;
    am_re = 1'b0;
    case (cmd.op)
      OP_CLR: begin
        fm_we = 1'b1; fm_wa = clr; fm_wd = (clr == node_of(po, '0));
        am_we = 1'b1; am_wa = clr[AW-1:0];
      end
      OP_SRD: begin
        fm_re = 1'b1; fm_ra = node_of(lvl, j << lvl);
      end
      OP_TAKE: begin
        fm_we = 1'b1; fm_wa = node_of(lvl, j << lvl);
      end
      OP_SPLIT: begin
        if (lvl > need) begin
          fm_we = 1'b1; fm_wd = 1'b1;
          fm_wa = node_of(lvl - ORD_W'(1), a + bit_lm1);
        end else begin
          am_we = 1'b1; am_wa = a; am_wd = {1'b1, need};
        end
      end
      OP_FRD: am_re = 1'b1;
      OP_FCHK: begin
        if (am_rd[ORD_W]) begin
          am_we = 1'b1; am_wa = a;
        end
      end
      OP_MRD: begin
        fm_re = 1'b1; fm_ra = node_of(lvl, a ^ bit_l);
      end
      OP_MCHK: begin
        if (fm_rd) begin
          fm_we = 1'b1; fm_wa = node_of(lvl, a ^ bit_l);
        end
      end
      OP_PUT: begin
        fm_we = 1'b1; fm_wd = 1'b1; fm_wa = node_of(lvl, a);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (fm_we) fm[fm_wa] <= fm_wd;
    if (fm_re) fm_rd <= fm[fm_ra];
  end

  always_ff @(posedge clk) begin
    if (am_we) am[am_wa] <= am_wd;
    if (am_re) am_rd <= am[a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      po_reg <= POOL_ORDER_RST;
      clr    <= '0;
      req    <= REQ_ALLOC;
    end else begin
      case (cmd.op)
        OP_CFG: begin
          po_reg <= pool_order;
          clr    <= '0;
        end
        OP_CLR:  clr <= clr + NW'(1);
        OP_LOAD: req <= req_type;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        need <= need_in;
        lvl  <= need_in;
        j    <= '0;
        a    <= AW'(address);
      end
      OP_SCHK: begin
        if (!fm_rd) begin
          if (j == lim_m1) begin
            lvl <= lvl + ORD_W'(1);
            j   <= '0;
          end else begin
            j <= j + AW'(1);
          end
        end
      end
      OP_TAKE:  a <= j << lvl;
      OP_SPLIT: begin
        if (lvl > need) begin
          lvl <= lvl - ORD_W'(1);
        end else begin
          status      <= ST_OK;
          address_res <= 10'(a);
          order       <= 4'(need);
        end
      end
      OP_OOM: begin
        status <= ST_OOM; address_res <= '0; order <= '0;
      end
      OP_FCHK: begin
        if (am_rd[ORD_W]) begin
          lvl         <= am_rd[ORD_W-1:0];
          status      <= ST_OK;
          address_res <= 10'(a);
          order       <= 4'(am_rd[ORD_W-1:0]);
        end else begin
          status <= ST_BAD; address_res <= '0; order <= '0;
        end
      end
      OP_MCHK: begin
        if (fm_rd) begin
          a   <= a & ~bit_l;
          lvl <= lvl + ORD_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/buddy_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_allocator_unit: binary buddy memory allocator, top level
// Allocates and frees power-of-two blocks in a pool of 2^pool_order units.
// ----------------------------------------------------------------------------
//  channel   signals                              transaction when
//  request   start, busy, req_type/size/address   start & !busy
//  result    done, status/address_res/order       done (one cycle, no stall)
//  config    cfg_valid, cfg_ready, pool_order     cfg_valid & cfg_ready
//
// Steps: an allocate hit scans N tree nodes, each a map read then a check,
// then takes the node and does s splits; allocate out of memory scans N
// nodes; a free looks up the table and does m merges, each a buddy read and
// check, plus a read and check if a buddy check fails; a bad free stops at
// the lookup. The search walks order by order, lowest address first, through
// the one free map port, so N reaches 2^(pool_order+1) - 1. The next request
// can be taken in the cycle after done. Reset and every pool_order write run
// a clearing pass over all 2^(ORDER_MAX+1) free map nodes and the allocation
// table; busy stays high. The result strobe cannot be held off; busy drops
// the cycle after done.
// ----------------------------------------------------------------------------
module buddy_allocator_unit import bau_pkg::*; #(
  parameter int ORDER_MAX = ORDER_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [10:0] size,
  input  logic [9:0]  address,
  output logic        done,
  output logic [1:0]  status,
  output logic [9:0]  address_res,
  output logic [3:0]  order,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  pool_order
);

  cmd_t  cmd;
  stat_t stat;

  // controller sees start only when idle; start has priority over config there
  bau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_valid (cfg_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  bau_dp #(.ORDER_MAX(ORDER_MAX)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .pool_order  (pool_order),
    .req_type    (req_type),
    .size        (size),
    .address     (address),
    .stat        (stat),
    .status      (status),
    .address_res (address_res),
    .order       (order)
  );

  assign busy      = cmd.busy;
  assign done      = cmd.done;
  assign cfg_ready = !cmd.busy && !start;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after result strobe");
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> busy) else $error("no clearing pass after config");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("request taken but not busy");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_OOM || status == ST_BAD))
    else $error("bad status code");

endmodule

@@ verif/tb_buddy_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_buddy_allocator_unit: self-checking testbench for the buddy allocator
// A queue-fed driver issues allocate and free requests. A monitor checks each
// result strobe against an in-bench model of the free map and allocation
// table. The pool order is rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_buddy_allocator_unit;
  import bau_pkg::*;

  localparam int OMAX = ORDER_MAX_DEF;

  typedef struct {
    logic        req_type;
    logic [10:0] size;
    logic [9:0]  address;
  } request_t;

  typedef struct {
    logic [1:0] status;
    logic [9:0] address_res;
    logic [3:0] order;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type = REQ_ALLOC;
  logic [10:0] size = '0;
  logic [9:0]  address = '0;
  logic        done;
  logic [1:0]  status;
  logic [9:0]  address_res;
  logic [3:0]  order;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  pool_order = POOL_ORDER_RST;

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  int       error_count = 0;
  int       sender_gap_pct = 0;

  // shadow allocator state
  bit       node_free[0:(2 << OMAX) - 1];
  bit [3:0] blk_order[0:(1 << OMAX) - 1];
  bit       blk_live[0:(1 << OMAX) - 1];
  int       pool_lg;

  buddy_allocator_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .req_type(req_type), .size(size), .address(address),
    .done(done), .status(status), .address_res(address_res), .order(order),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .pool_order(pool_order)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int node_idx(int o, int a);
    return (1 << (OMAX - o)) + (a >> o);
  endfunction

  // reinitialize: only the whole pool is free, no live allocations
  function automatic void pool_reinit(logic [3:0] po);
    pool_lg = (int'(po) > OMAX) ? OMAX : int'(po);
    foreach (node_free[i]) node_free[i] = 0;
    foreach (blk_live[i]) blk_live[i] = 0;
    node_free[node_idx(pool_lg, 0)] = 1;
  endfunction

  function automatic grant_t buddy_serve(request_t r);
    grant_t g;
    int need, o, a, bud, sz;
    bit found;
    g = '{ST_OK, '0, '0};
    if (r.req_type == REQ_ALLOC) begin
      sz = (r.size == 0) ? 1 : int'(r.size);
      need = 0;
      while (need < 12 && (1 << need) < sz) need++;
      found = 0;
      a = 0;
      for (o = need; o <= pool_lg && !found; o++) begin
        for (a = 0; a < (1 << pool_lg); a += (1 << o))
          if (node_free[node_idx(o, a)]) begin
            found = 1;
            break;
          end
        if (found) break;
      end
      if (!found) begin
        g.status = ST_OOM;
      end else begin
        node_free[node_idx(o, a)] = 0;
        while (o > need) begin
          o--;
          node_free[node_idx(o, a + (1 << o))] = 1;
        end
        blk_order[a] = 4'(need);
        blk_live[a] = 1;
        g.address_res = 10'(a);
        g.order = 4'(need);
      end
    end else begin
      a = int'(r.address);
      if (!blk_live[a]) begin
        g.status = ST_BAD;
      end else begin
        o = int'(blk_order[a]);
        blk_live[a] = 0;
        g.address_res = 10'(a);
        g.order = 4'(o);
        // coalesce upward while the buddy is free
        while (o < pool_lg) begin
          bud = a ^ (1 << o);
          if (!node_free[node_idx(o, bud)]) break;
          node_free[node_idx(o, bud)] = 0;
          if (bud < a) a = bud;
          o++;
        end
        node_free[node_idx(o, a)] = 1;
      end
    end
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // driver: a transaction completes on start & !busy; next item loads at once
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start)
        expected_grants.push_back(buddy_serve('{req_type, size, address}));
      if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_gap_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        req_type <= r.req_type;
        size     <= r.size;
        address  <= r.address;
        start    <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every done strobe is one result transaction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_grants.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        grant_t e;
        e = expected_grants.pop_front();
        if (status !== e.status) report_mismatch("status", status, e.status);
        if (address_res !== e.address_res)
          report_mismatch("address_res", address_res, e.address_res);
        if (order !== e.order) report_mismatch("order", order, e.order);
      end
    end
  end

  task automatic push_req(logic rt, int sz, int ad);
    pending_reqs.push_back('{rt, sz[10:0], ad[9:0]});
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || start || expected_grants.size() > 0)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_pool_order(logic [3:0] po);
    drain();
    cfg_valid  <= 1'b1;
    pool_order <= po;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    pool_reinit(po);
  endtask

  // random traffic: mostly allocs and frees of live blocks, some noise
  task automatic random_traffic(int n);
    int live[$];
    int pick, k;
    for (int i = 0; i < n; i++) begin
      while (pending_reqs.size() > 1) @(posedge clk);
      sender_gap_pct = (i < n / 3) ? 34 : (i < 2 * n / 3) ? 55 : 0;
      pick = $urandom_range(99);
      live.delete();
      foreach (blk_live[j]) if (blk_live[j]) live.push_back(j);
      if (pick < 45 || (pick < 85 && live.size() == 0)) begin
        k = $urandom_range(pool_lg);
        push_req(REQ_ALLOC, 0, $urandom);
        pending_reqs[$].size = 11'($urandom_range(1 << k));
        if ($urandom_range(19) == 0) pending_reqs[$].size = 11'($urandom);
      end else if (pick < 85) begin
        push_req(REQ_FREE, $urandom, live[$urandom_range(live.size() - 1)]);
      end else begin
        push_req(REQ_FREE, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    logic [3:0] phase_orders[10];
    phase_orders = '{4'd0, 4'd15, 4'd3, 4'd5, 4'd2,
                     4'd11, 4'd6, 4'd4, 4'd10, 4'd1};
    pool_reinit(POOL_ORDER_RST);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: size extremes, oversize, bad frees, merges, top address
    push_req(REQ_ALLOC, 0, 0);
    push_req(REQ_ALLOC, 1, 1023);
    push_req(REQ_ALLOC, 3, 0);
    push_req(REQ_ALLOC, 513, 0);
    push_req(REQ_ALLOC, 1025, 0);
    push_req(REQ_ALLOC, 2047, 0);
    push_req(REQ_FREE, 0, 1);
    push_req(REQ_FREE, 0, 1023);
    push_req(REQ_FREE, 0, 3);
    push_req(REQ_FREE, 0, 0);
    push_req(REQ_FREE, 0, 0);
    push_req(REQ_FREE, 2047, 1);
    push_req(REQ_FREE, 0, 4);
    push_req(REQ_FREE, 0, 512);
    push_req(REQ_ALLOC, 1024, 0);
    push_req(REQ_ALLOC, 1, 0);
    push_req(REQ_FREE, 0, 0);
    push_req(REQ_ALLOC, 1024, 0);
    push_req(REQ_FREE, 0, 0);
    random_traffic(80);

    foreach (phase_orders[p]) begin
      write_pool_order(phase_orders[p]);
      push_req(REQ_ALLOC, 1 << ((phase_orders[p] > OMAX) ? OMAX : phase_orders[p]), 0);
      push_req(REQ_ALLOC, 1, 0);
      push_req(REQ_FREE, 0, 0);
      push_req(REQ_FREE, 0, 1023);
      random_traffic(150);
    end

    drain();
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ buddy_allocator_unit.f @@
rtl/core/bau_pkg.sv
rtl/core/bau_ctrl.sv
rtl/core/bau_dp.sv
rtl/core/buddy_allocator_unit.sv
verif/tb_buddy_allocator_unit.sv
